>>> hdl/ssr_pkg.sv
// shared constants, register indexes and window interface types
package ssr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_REPLACE_DEF = 8;

    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 2'd3;

    // commands from the sequencer to the window row
    typedef struct packed {
        logic load;
        logic pop;
    } win_cmd_t;

    // status from the window row back to the sequencer
    typedef struct packed {
        logic       all_match;
        logic [7:0] head;
    } win_stat_t;

endpackage

>>> hdl/ssr_cell.sv
// one window cell: holds a pending byte, shifts toward the head on pop
module ssr_cell (
    input  logic       clk,
    input  logic       load,
    input  logic       pop,
    input  logic [7:0] in_char,
    input  logic [7:0] upper_byte,
    input  logic [7:0] pat_byte,
    output logic [7:0] cur_byte,
    output logic       eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // cur_byte is the value after this cycle's append
    always_comb
    begin
        cur_byte  = load ? in_char : byte_reg;
        byte_next = pop ? upper_byte : cur_byte;
        eq        = (cur_byte == pat_byte);
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

>>> hdl/ssr_window.sv
// row of window cells with per-cell pattern compare
module ssr_window #(
    parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
    parameter int CW          = $clog2(MAX_PATTERN + 1)
) (
    input  logic                    clk,
    input  ssr_pkg::win_cmd_t       cmd,
    input  logic [CW-1:0]           wr_idx,
    input  logic [CW-1:0]           plen,
    input  logic [7:0]              in_char,
    input  logic [ssr_pkg::CFG_W-1:0] pattern_bytes,
    output ssr_pkg::win_stat_t      stat
);

    logic [7:0]             post [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] ok;

    // nothing above the last cell
    assign post[MAX_PATTERN] = 8'd0;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic eq;

        ssr_cell u_cell (
            .clk        (clk),
            .load       (cmd.load && (wr_idx == IDX)),
            .pop        (cmd.pop),
            .in_char    (in_char),
            .upper_byte (post[i+1]),
            .pat_byte   (pattern_bytes[8*i +: 8]),
            .cur_byte   (post[i]),
            .eq         (eq)
        );

        // cells past the pattern length do not take part
        assign ok[i] = eq || (IDX >= plen);
    end

    assign stat.all_match = &ok;
    assign stat.head      = post[0];

endmodule

>>> hdl/stream_substring_replace_unit.sv
// top level: streaming find-and-replace-all of a configured substring
// Takes one byte per beat and rewrites every leftmost, non-overlapping
// occurrence of the pattern (1..8 bytes) with the replacement (0..8 bytes).
// Plain text runs at one beat per cycle unless a replacement, a flush or a
// stalled output holds input off. A match with an R-byte replacement sends
// R bytes, and input is held while the last R-1 of them go out; an end beat
// is followed by one output beat per pending window byte and then the
// terminal beat, which carries tlast and the found flag. The output register
// lets a new beat be taken in the cycle the previous result is accepted.
// Configuration must be written only while idle; the block does not enforce it.
module stream_substring_replace_unit #(
    parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACE = ssr_pkg::MAX_REPLACE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_wr_en,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssr_pkg::CFG_W-1:0]         cfg_wdata,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // in_char
    input  logic                              s_axis_tlast,  // in_end
    input  logic [0:0]                        s_axis_tuser,  // in_valid

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // out_char
    output logic                              m_axis_tlast,  // out_last
    output logic [1:0]                        m_axis_tuser   // char_valid, found_any
);

    localparam int CW  = $clog2(MAX_PATTERN + 1);
    localparam int RLW = $clog2(MAX_REPLACE + 1);
    localparam int RIW = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;
    localparam logic [CW-1:0]              MAXP_C = CW'(MAX_PATTERN);
    localparam logic [ssr_pkg::LEN_W-1:0]  MAXP_L = ssr_pkg::LEN_W'(MAX_PATTERN);
    localparam logic [ssr_pkg::LEN_W-1:0]  MAXR_L = ssr_pkg::LEN_W'(MAX_REPLACE);

    // configuration registers
    logic [ssr_pkg::CFG_W-1:0] pattern_bytes_reg;
    logic [ssr_pkg::LEN_W-1:0] pattern_len_reg;
    logic [ssr_pkg::CFG_W-1:0] replace_bytes_reg;
    logic [ssr_pkg::LEN_W-1:0] replace_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg <= '0;
            pattern_len_reg   <= ssr_pkg::LEN_W'(1);
            replace_bytes_reg <= '0;
            replace_len_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ssr_pkg::REG_PATTERN_BYTES: pattern_bytes_reg <= cfg_wdata;
                ssr_pkg::REG_PATTERN_LEN:   pattern_len_reg   <= cfg_wdata[ssr_pkg::LEN_W-1:0];
                ssr_pkg::REG_REPLACE_BYTES: replace_bytes_reg <= cfg_wdata;
                ssr_pkg::REG_REPLACE_LEN:   replace_len_reg   <= cfg_wdata[ssr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective lengths
    logic [ssr_pkg::LEN_W-1:0] plen_l;
    logic [ssr_pkg::LEN_W-1:0] rlen_l;
    logic [CW-1:0]             plen;
    logic [RLW-1:0]            rlen;

    always_comb
    begin
        if (pattern_len_reg == '0)
            plen_l = ssr_pkg::LEN_W'(1);
        else if (pattern_len_reg > MAXP_L)
            plen_l = MAXP_L;
        else
            plen_l = pattern_len_reg;
        rlen_l = (replace_len_reg > MAXR_L) ? MAXR_L : replace_len_reg;
        plen   = CW'(plen_l);
        rlen   = RLW'(rlen_l);
    end

    // sequencer state
    logic [CW-1:0]  count_reg, count_next;
    logic           seen_reg, seen_next;
    logic [RLW-1:0] rep_left_reg, rep_left_next;
    logic [RIW-1:0] rep_idx_reg, rep_idx_next;
    logic           flush_reg, flush_next;

    // output register
    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_char_reg, m_char_next;
    logic           m_cv_reg, m_cv_next;
    logic           m_last_reg, m_last_next;
    logic           m_found_reg, m_found_next;

    ssr_pkg::win_cmd_t  cmd;
    ssr_pkg::win_stat_t stat;

    logic          can_load, busy, acc, app, hit, ge;
    logic [CW-1:0] c1;

    ssr_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .CW          (CW)
    ) u_window (
        .clk           (clk),
        .cmd           (cmd),
        .wr_idx        (count_reg),
        .plen          (plen),
        .in_char       (s_axis_tdata),
        .pattern_bytes (pattern_bytes_reg),
        .stat          (stat)
    );

    always_comb
    begin
        can_load      = !m_valid_reg || m_axis_tready;
        busy          = (rep_left_reg != '0) || flush_reg;
        s_axis_tready = !busy && can_load;
        acc           = s_axis_tvalid && s_axis_tready;
        app           = acc && s_axis_tuser[0] && (count_reg < MAXP_C);
        c1            = count_reg + CW'(1);
        ge            = (c1 >= plen);
        hit           = app && (c1 == plen) && stat.all_match;

        cmd.load      = app;
        cmd.pop       = 1'b0;

        count_next    = count_reg;
        seen_next     = seen_reg;
        rep_left_next = rep_left_reg;
        rep_idx_next  = rep_idx_reg;
        flush_next    = flush_reg;

        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_char_next   = m_char_reg;
        m_cv_next     = m_cv_reg;
        m_last_next   = m_last_reg;
        m_found_next  = m_found_reg;

        if (acc)
        begin
            if (app)
            begin
                count_next = c1;
                if (hit)
                begin
                    count_next = '0;
                    seen_next  = 1'b1;
                    if (rlen != '0)
                    begin
                        m_valid_next  = 1'b1;
                        m_char_next   = replace_bytes_reg[7:0];
                        m_cv_next     = 1'b1;
                        m_last_next   = 1'b0;
                        m_found_next  = 1'b0;
                        rep_left_next = rlen - RLW'(1);
                        rep_idx_next  = RIW'(1);
                    end
                end
                else if (ge)
                begin
                    cmd.pop      = 1'b1;
                    count_next   = c1 - CW'(1);
                    m_valid_next = 1'b1;
                    m_char_next  = stat.head;
                    m_cv_next    = 1'b1;
                    m_last_next  = 1'b0;
                    m_found_next = 1'b0;
                end
            end
            flush_next = s_axis_tlast;
        end
        else if (busy && can_load)
        begin
            m_valid_next = 1'b1;
            if (rep_left_reg != '0)
            begin
                m_char_next   = replace_bytes_reg[8*rep_idx_reg +: 8];
                m_cv_next     = 1'b1;
                m_last_next   = 1'b0;
                m_found_next  = 1'b0;
                rep_left_next = rep_left_reg - RLW'(1);
                rep_idx_next  = rep_idx_reg + RIW'(1);
            end
            else if (count_reg != '0)
            begin
                // flush the oldest pending byte
                cmd.pop      = 1'b1;
                count_next   = count_reg - CW'(1);
                m_char_next  = stat.head;
                m_cv_next    = 1'b1;
                m_last_next  = 1'b0;
                m_found_next = 1'b0;
            end
            else
            begin
                // terminal beat of the string
                m_char_next  = 8'd0;
                m_cv_next    = 1'b0;
                m_last_next  = 1'b1;
                m_found_next = seen_reg;
                seen_next    = 1'b0;
                flush_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            seen_reg     <= 1'b0;
            rep_left_reg <= '0;
            rep_idx_reg  <= '0;
            flush_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            seen_reg     <= seen_next;
            rep_left_reg <= rep_left_next;
            rep_idx_reg  <= rep_idx_next;
            flush_reg    <= flush_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_char_reg  <= m_char_next;
        m_cv_reg    <= m_cv_next;
        m_last_reg  <= m_last_next;
        m_found_reg <= m_found_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_char_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = {m_found_reg, m_cv_reg};

endmodule
